@@ src/stack_machine_ops_top_macros.svh @@
// Assertion macros used by the checker file smp_checker.sv.
// Each macro samples on posedge clk and is disabled while rst_n is low.
`ifndef STACK_MACHINE_OPS_TOP_MACROS_SVH
`define STACK_MACHINE_OPS_TOP_MACROS_SVH

// Same-cycle implication: cons must hold whenever ante holds.
`define SMP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication: cons must hold in the cycle after ante.
`define SMP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ src/smp_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smp_pkg: shared types and codes of the stack machine
// Word type, instruction and status codes, cell load selects.
// ----------------------------------------------------------------------------
package smp_pkg;

  localparam int WORD_W    = 32;
  localparam int DEPTH_DEF = 32;
  localparam int MODE_W    = 3;
  localparam int STAT_W    = 3;

  typedef logic signed [WORD_W-1:0] word_t;
  typedef logic [MODE_W-1:0]        mode_t;
  typedef logic [STAT_W-1:0]        stat_t;
  typedef logic [1:0]               cell_sel_t;

  // Instructions
  localparam mode_t MODE_PUSH  = 3'd0;
  localparam mode_t MODE_PRINT = 3'd1;
  localparam mode_t MODE_PEEK  = 3'd2;
  localparam mode_t MODE_POP   = 3'd3;
  localparam mode_t MODE_SWAP  = 3'd4;

  // Result status
  localparam stat_t STAT_OK         = 3'd0;
  localparam stat_t STAT_PEEK_EMPTY = 3'd1;
  localparam stat_t STAT_POP_EMPTY  = 3'd2;
  localparam stat_t STAT_SWAP_SHORT = 3'd3;
  localparam stat_t STAT_PUSH_FULL  = 3'd4;

  // Cell load selects
  localparam cell_sel_t SEL_HOLD  = 2'd0;
  localparam cell_sel_t SEL_ABOVE = 2'd1;
  localparam cell_sel_t SEL_BELOW = 2'd2;
  localparam cell_sel_t SEL_TOP   = 2'd3;

endpackage

@@ src/smp_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smp_cell: one stack entry
// Holds one word; loads from its upper or lower neighbor or from the top.
// ----------------------------------------------------------------------------
module smp_cell (
  input  logic              clk,
  input  smp_pkg::cell_sel_t sel,
  input  smp_pkg::word_t    from_above,
  input  smp_pkg::word_t    from_below,
  input  smp_pkg::word_t    top_in,
  output smp_pkg::word_t    q
);
  import smp_pkg::*;

  word_t q_r;
  word_t q_nxt;

  always_comb begin
    case (sel)
      SEL_ABOVE: q_nxt = from_above;
      SEL_BELOW: q_nxt = from_below;
      SEL_TOP:   q_nxt = top_in;
      default:   q_nxt = q_r;
    endcase
  end

  // entry data needs no reset
  always_ff @(posedge clk) begin
    q_r <= q_nxt;
  end

  assign q = q_r;

endmodule

@@ src/stack_machine_ops_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stack_machine_ops_top: bounded LIFO stack executing stack instructions
// Row of entry cells with the top in cell 0, plus the instruction sequencer.
// ----------------------------------------------------------------------------
// Usage:
//   Drive in_mode / in_push_value with start high; the request is taken at a
//   rising edge where start is high and busy is low.
//   Push, pop, peek, swap and unused codes: one result, strobed on out_valid
//   in the cycle right after the request. busy stays low, so a new request
//   can follow every cycle (one instruction per clock).
//   Print all with N entries: N results in consecutive cycles, top entry
//   first, the bottom entry marked by out_last. busy is high during the
//   cycles in which results 1 to N-1 are shown, so the instruction holds
//   the block until its last result, rotating the ring through the cells.
//   Print all on an empty stack gives one result without a value.
//   Failed instructions report out_status and leave the stack unchanged.
//   Each result is valid for exactly one cycle; the receiver cannot stall.
//   Synchronous reset (rst_n low) empties the stack and drops any print in
//   progress; entry contents are not cleared and are never read unwritten.
// ----------------------------------------------------------------------------
module stack_machine_ops_top #(
  parameter int DEPTH = smp_pkg::DEPTH_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  output logic           busy,
  input  smp_pkg::mode_t in_mode,
  input  smp_pkg::word_t in_push_value,
  output logic           out_valid,
  output smp_pkg::word_t out_value,
  output logic           out_has_value,
  output smp_pkg::stat_t out_status,
  output logic           out_last
);
  import smp_pkg::*;

  localparam int CNT_W = $clog2(DEPTH + 1);

  // sequencer states
  localparam logic S_IDLE  = 1'b0;
  localparam logic S_PRINT = 1'b1;

  // whole-row operations
  localparam logic [2:0] OP_HOLD = 3'd0;
  localparam logic [2:0] OP_PUSH = 3'd1;
  localparam logic [2:0] OP_POP  = 3'd2;
  localparam logic [2:0] OP_SWAP = 3'd3;
  localparam logic [2:0] OP_ROT  = 3'd4;

  logic             state_r, state_nxt;
  logic [CNT_W-1:0] fill_r, fill_nxt;
  logic [CNT_W-1:0] rem_r, rem_nxt;
  logic             valid_r, valid_nxt;
  word_t            value_r, value_nxt;
  logic             has_r, has_nxt;
  stat_t            stat_r, stat_nxt;
  logic             last_r, last_nxt;
  logic [2:0]       op;
  logic             accept;

  word_t     cell_q   [DEPTH];
  cell_sel_t cell_sel [DEPTH];

  assign busy   = (state_r == S_PRINT);
  assign accept = start && !busy;

  // Sequencer: decode the request, pick the row operation, build the result.
  always_comb begin
    state_nxt = state_r;
    fill_nxt  = fill_r;
    rem_nxt   = rem_r;
    valid_nxt = 1'b0;
    value_nxt = '0;
    has_nxt   = 1'b0;
    stat_nxt  = STAT_OK;
    last_nxt  = 1'b1;
    op        = OP_HOLD;
    if (state_r == S_PRINT) begin
      // emit the current top, rotate the next entry up
      valid_nxt = 1'b1;
      value_nxt = cell_q[0];
      has_nxt   = 1'b1;
      op        = OP_ROT;
      rem_nxt   = rem_r - CNT_W'(1);
      last_nxt  = (rem_r == CNT_W'(1));
      if (rem_r == CNT_W'(1)) begin
        state_nxt = S_IDLE;
      end
    end else if (accept) begin
      valid_nxt = 1'b1;
      unique case (in_mode)
        MODE_PUSH: begin
          if (fill_r == CNT_W'(DEPTH)) begin
            stat_nxt = STAT_PUSH_FULL;
          end else begin
            op       = OP_PUSH;
            fill_nxt = fill_r + CNT_W'(1);
          end
        end
        MODE_PRINT: begin
          if (fill_r != '0) begin
            value_nxt = cell_q[0];
            has_nxt   = 1'b1;
            op        = OP_ROT;
            last_nxt  = (fill_r == CNT_W'(1));
            if (fill_r != CNT_W'(1)) begin
              state_nxt = S_PRINT;
              rem_nxt   = fill_r - CNT_W'(1);
            end
          end
        end
        MODE_PEEK: begin
          if (fill_r == '0) begin
            stat_nxt = STAT_PEEK_EMPTY;
          end else begin
            value_nxt = cell_q[0];
            has_nxt   = 1'b1;
          end
        end
        MODE_POP: begin
          if (fill_r == '0) begin
            stat_nxt = STAT_POP_EMPTY;
          end else begin
            op       = OP_POP;
            fill_nxt = fill_r - CNT_W'(1);
          end
        end
        MODE_SWAP: begin
          if (fill_r < CNT_W'(2)) begin
            stat_nxt = STAT_SWAP_SHORT;
          end else begin
            op = OP_SWAP;
          end
        end
        default: begin
          // unused codes: plain ok result, no effect
        end
      endcase
    end
  end

  // Cell row: cell 0 is the top of the stack.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    word_t above;
    word_t below;
    logic  wrap;

    if (i == 0) begin : g_first
      assign above = in_push_value;
    end else begin : g_inner_a
      assign above = cell_q[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign below = '0;
    end else begin : g_inner_b
      assign below = cell_q[i+1];
    end

    // bottom entry of the ring takes the old top while printing
    assign wrap = (fill_r == CNT_W'(i + 1));

    always_comb begin
      case (op)
        OP_PUSH: cell_sel[i] = SEL_ABOVE;
        OP_POP:  cell_sel[i] = SEL_BELOW;
        OP_ROT:  cell_sel[i] = wrap ? SEL_TOP : SEL_BELOW;
        OP_SWAP: begin
          if (i == 0) begin
            cell_sel[i] = SEL_BELOW;
          end else if (i == 1) begin
            cell_sel[i] = SEL_ABOVE;
          end else begin
            cell_sel[i] = SEL_HOLD;
          end
        end
        default: cell_sel[i] = SEL_HOLD;
      endcase
    end

    smp_cell u_cell (
      .clk        (clk),
      .sel        (cell_sel[i]),
      .from_above (above),
      .from_below (below),
      .top_in     (cell_q[0]),
      .q          (cell_q[i])
    );
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      fill_r  <= '0;
      rem_r   <= '0;
      valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      fill_r  <= fill_nxt;
      rem_r   <= rem_nxt;
      valid_r <= valid_nxt;
    end
  end

  // Result payload, qualified by valid_r
  always_ff @(posedge clk) begin
    value_r <= value_nxt;
    has_r   <= has_nxt;
    stat_r  <= stat_nxt;
    last_r  <= last_nxt;
  end

  assign out_valid     = valid_r;
  assign out_value     = value_r;
  assign out_has_value = has_r;
  assign out_status    = stat_r;
  assign out_last      = last_r;

endmodule

@@ src/smp_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smp_checker: port-level checks of the stack machine
// Watches requests, busy and the result strobe over time.
// ----------------------------------------------------------------------------
`include "stack_machine_ops_top_macros.svh"

module smp_checker (
  input logic           clk,
  input logic           rst_n,
  input logic           start,
  input logic           busy,
  input logic           out_valid,
  input logic           out_has_value,
  input smp_pkg::stat_t out_status,
  input logic           out_last
);
  import smp_pkg::*;

  `SMP_ASSERT_NEXT(a_req_result, start && !busy, out_valid, "request gave no result")
  `SMP_ASSERT_NEXT(a_print_emits, busy, out_valid, "print cycle without result")
  `SMP_ASSERT_NOW(a_more_busy, out_valid && !out_last, busy, "more results due but not busy")
  `SMP_ASSERT_NOW(a_last_free, out_valid && out_last, !busy, "busy after final result")
  `SMP_ASSERT_NOW(a_err_single, out_valid && out_status != STAT_OK, out_last && !out_has_value, "error result malformed")

endmodule

bind stack_machine_ops_top smp_checker u_smp_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .start         (start),
  .busy          (busy),
  .out_valid     (out_valid),
  .out_has_value (out_has_value),
  .out_status    (out_status),
  .out_last      (out_last)
);

@@ tb/sv/stack_machine_ops_top_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stack_machine_ops_top_test: self-checking bench for the stack machine
// Drives push, print-all, peek, pop, swap and spare opcodes through the
// start/busy request port and checks every strobed result, field by field,
// against a behavioral stack kept in a small scoreboard class. A directed
// opening covers the empty-stack faults and the value extremes. Random
// segments then fill the stack to overflow, drain it to underflow and mix
// instructions, with the sender idling at several rates.
// ----------------------------------------------------------------------------
module stack_machine_ops_top_test;
  import smp_pkg::*;

  localparam int    DEPTH         = DEPTH_DEF;
  localparam int    RANDOM_ITEMS  = 400;
  localparam int    SETTLE_CYCLES = 2 * DEPTH + 8;  // covers a full print-all
  localparam int    CYCLE_LIMIT   = 400000;
  // Codes 5 to 7 are spare: the block takes them and answers with a bare ok.
  localparam mode_t MODE_SPARE_LO = MODE_SWAP + 3'd1;
  localparam mode_t MODE_SPARE_HI = '1;

  typedef struct {
    word_t value;
    logic  has_value;
    stat_t status;
    logic  last;
  } stack_result_t;

  // --------------------------------------------------------------------------
  // Scoreboard: holds its own copy of the stack and the queue of results that
  // the accepted requests must produce, oldest first.
  // --------------------------------------------------------------------------
  class stack_scoreboard;
    word_t         entries[DEPTH];
    int            fill;
    stack_result_t pending_results[$];
    int            errors;
    int            n_requests;
    int            n_results;
    int            n_prints;
    int            n_faults;
    int            n_full_pushes;

    function new();
      fill          = 0;
      errors        = 0;
      n_requests    = 0;
      n_results     = 0;
      n_prints      = 0;
      n_faults      = 0;
      n_full_pushes = 0;
    endfunction

    function void queue_result(word_t value, logic has_value, stat_t status, logic last);
      stack_result_t r;
      r.value     = value;
      r.has_value = has_value;
      r.status    = status;
      r.last      = last;
      if (status != STAT_OK) n_faults++;
      pending_results.push_back(r);
    endfunction

    // Apply one accepted request to the stack copy and queue what it yields.
    function void note_request(mode_t mode, word_t value);
      word_t tmp;
      n_requests++;
      case (mode)
        MODE_PUSH: begin
          if (fill >= DEPTH) begin
            n_full_pushes++;
            queue_result('0, 1'b0, STAT_PUSH_FULL, 1'b1);
          end else begin
            entries[fill] = value;
            fill++;
            queue_result('0, 1'b0, STAT_OK, 1'b1);
          end
        end
        MODE_PRINT: begin
          n_prints++;
          if (fill == 0) begin
            queue_result('0, 1'b0, STAT_OK, 1'b1);
          end else begin
            for (int i = fill; i > 0; i--)
              queue_result(entries[i-1], 1'b1, STAT_OK, i == 1);
          end
        end
        MODE_PEEK: begin
          if (fill == 0) queue_result('0, 1'b0, STAT_PEEK_EMPTY, 1'b1);
          else queue_result(entries[fill-1], 1'b1, STAT_OK, 1'b1);
        end
        MODE_POP: begin
          if (fill == 0) begin
            queue_result('0, 1'b0, STAT_POP_EMPTY, 1'b1);
          end else begin
            fill--;
            queue_result('0, 1'b0, STAT_OK, 1'b1);
          end
        end
        MODE_SWAP: begin
          if (fill < 2) begin
            queue_result('0, 1'b0, STAT_SWAP_SHORT, 1'b1);
          end else begin
            tmp             = entries[fill-1];
            entries[fill-1] = entries[fill-2];
            entries[fill-2] = tmp;
            queue_result('0, 1'b0, STAT_OK, 1'b1);
          end
        end
        default: queue_result('0, 1'b0, STAT_OK, 1'b1);
      endcase
    endfunction

    function void check_result(word_t value, logic has_value, stat_t status, logic last);
      stack_result_t want;
      n_results++;
      if (pending_results.size() == 0) begin
        $error("result with nothing pending: out_value %0d, out_status %0d", value, status);
        errors++;
        return;
      end
      want = pending_results.pop_front();
      if (value !== want.value) begin
        $error("out_value: expected %0d, got %0d", want.value, value);
        errors++;
      end
      if (has_value !== want.has_value) begin
        $error("out_has_value: expected %0b, got %0b", want.has_value, has_value);
        errors++;
      end
      if (status !== want.status) begin
        $error("out_status: expected %0d, got %0d", want.status, status);
        errors++;
      end
      if (last !== want.last) begin
        $error("out_last: expected %0b, got %0b", want.last, last);
        errors++;
      end
    endfunction

    function int pending();
      return pending_results.size();
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Block under test
  // --------------------------------------------------------------------------
  logic  clk;
  logic  rst_n;
  logic  start;
  logic  busy;
  mode_t in_mode;
  word_t in_push_value;
  logic  out_valid;
  word_t out_value;
  logic  out_has_value;
  stat_t out_status;
  logic  out_last;

  stack_machine_ops_top #(
    .DEPTH(DEPTH)
  ) DUT (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_mode      (in_mode),
    .in_push_value(in_push_value),
    .out_valid    (out_valid),
    .out_value    (out_value),
    .out_has_value(out_has_value),
    .out_status   (out_status),
    .out_last     (out_last)
  );

  stack_scoreboard scoreboard = new();

  int accepted;     // requests taken by the block so far
  int items_sent;   // requests with a real instruction code
  int idle_pct;     // chance, in percent, that the sender idles before a request
  int cycles;

  // 8 ns clock.
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Watch both channels at every rising edge. Check the result first and note
  // the request second: a result at this edge always belongs to an earlier
  // request, so the oldest pending entry is the one to compare against.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid)
        scoreboard.check_result(out_value, out_has_value, out_status, out_last);
      if (start && !busy) begin
        scoreboard.note_request(in_mode, in_push_value);
        accepted++;
      end
    end
  end

  // Hard stop in case the block hangs or stops answering.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("stack_machine_ops_top_test NOT OK");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Request driver
  // --------------------------------------------------------------------------
  // Present one request and hold it until the block takes it. Start stays high
  // across back-to-back requests; it drops only for an idle gap, so it never
  // gets two assignments in the same step.
  task automatic send_request(input mode_t mode, input word_t value);
    int target;
    if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    target = accepted + 1;
    start         <= 1'b1;
    in_mode       <= mode;
    in_push_value <= value;
    // The monitor bumps the count at the accepting edge.
    wait (accepted == target);
    if (mode <= MODE_SWAP) items_sent++;
  endtask

  // Hold off new requests until every pending result has come back.
  task automatic drain_results();
    start <= 1'b0;
    while (scoreboard.pending() != 0) @(posedge clk);
  endtask

  function automatic mode_t pick_mode();
    int r;
    r = $urandom_range(0, 99);
    if (r < 35) return MODE_PUSH;
    if (r < 45) return MODE_PRINT;
    if (r < 62) return MODE_PEEK;
    if (r < 80) return MODE_POP;
    if (r < 95) return MODE_SWAP;
    return mode_t'($urandom_range(MODE_SPARE_LO, MODE_SPARE_HI));
  endfunction

  // One stretch of random traffic: fill to overflow, drain to underflow, or a
  // random mix that walks the depth up and down.
  task automatic run_segment();
    int kind;
    kind = $urandom_range(0, 9);
    if (kind < 2) begin
      while (scoreboard.fill < DEPTH) send_request(MODE_PUSH, $urandom());
      send_request(MODE_PUSH, $urandom());
      send_request(MODE_PEEK, $urandom());
      send_request(MODE_PRINT, $urandom());
    end else if (kind < 4) begin
      while (scoreboard.fill > 0) send_request(MODE_POP, $urandom());
      send_request(MODE_POP, $urandom());
      send_request(MODE_PEEK, $urandom());
      send_request(MODE_SWAP, $urandom());
      send_request(MODE_PRINT, $urandom());
    end else begin
      repeat (20) send_request(pick_mode(), $urandom());
    end
  endtask

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin
    int phase_goal;
    int phase_idle[3];

    start         <= 1'b0;
    rst_n         <= 1'b0;
    in_mode       <= MODE_PUSH;
    in_push_value <= '0;
    idle_pct       = 0;
    phase_idle     = '{0, 63, 10};

    // Hold reset, then release it once.
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed opening: faults on an empty stack, spare codes, value extremes,
    // a swap on a single entry, and a print-all of a short stack.
    send_request(MODE_PEEK, '0);
    send_request(MODE_POP, '0);
    send_request(MODE_SWAP, '0);
    send_request(MODE_PRINT, '0);
    send_request(MODE_SPARE_LO, 32'h1234_5678);
    send_request(MODE_SPARE_LO + 3'd1, '1);
    send_request(MODE_SPARE_HI, 32'h8000_0000);
    send_request(MODE_PUSH, 32'h7FFF_FFFF);
    send_request(MODE_SWAP, '0);
    send_request(MODE_PEEK, '0);
    send_request(MODE_PUSH, 32'h8000_0000);
    send_request(MODE_PUSH, '0);
    send_request(MODE_PUSH, 32'hFFFF_FFFF);
    send_request(MODE_SWAP, '1);
    send_request(MODE_PEEK, '1);
    send_request(MODE_PRINT, '1);
    send_request(MODE_PUSH, 32'h5555_5555);
    send_request(MODE_PUSH, 32'hAAAA_AAAA);
    send_request(MODE_PRINT, '0);
    repeat (5) send_request(MODE_POP, '0);
    send_request(MODE_POP, '0);
    send_request(MODE_PRINT, '0);
    drain_results();

    // Random part in phases: back to back, heavy sender idling, light idling.
    // Drain at each phase end so the block also sees a fully idle pause.
    for (int phase = 0; phase < 3; phase++) begin
      idle_pct   = phase_idle[phase];
      phase_goal = items_sent + RANDOM_ITEMS / 3;
      while (items_sent < phase_goal) run_segment();
      drain_results();
    end

    // Let any stray strobe show up before the verdict.
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Ran %0d requests (%0d print-all) and checked %0d results in %0d cycles.",
             scoreboard.n_requests, scoreboard.n_prints, scoreboard.n_results, cycles);
    $display("Fault statuses seen: %0d, of which %0d were pushes onto a full stack.",
             scoreboard.n_faults, scoreboard.n_full_pushes);
    if (scoreboard.errors == 0 && scoreboard.pending() == 0) begin
      $display("stack_machine_ops_top_test OK");
    end else begin
      $display("stack_machine_ops_top_test NOT OK");
    end
    $finish;
  end

endmodule

@@ files.f @@
+incdir+src
src/smp_pkg.sv
src/smp_cell.sv
src/stack_machine_ops_top.sv
src/smp_checker.sv
tb/sv/stack_machine_ops_top_test.sv
